// File: design/pxv_pkg.sv
// Shared widths, defaults and codes for the proximity hysteresis verdict block.
package pxv_pkg;

  localparam int unsigned DIST_W = 16;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CRIT_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [CNT_W-1:0]  CNT_MAX         = '1;
  localparam logic [DIST_W-1:0] NEAR_DEFAULT_CM = 16'd150;
  localparam logic [DIST_W-1:0] AWAY_DEFAULT_CM = 16'd300;
  localparam logic [DIST_W:0]   BAND_GAP_CM     = 17'd50;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_NEAR_THRESHOLD = 1'b0,
    REG_AWAY_THRESHOLD = 1'b1
  } reg_index_t;

  typedef enum logic [CRIT_W-1:0] {
    CRIT_STAY_NEAR  = 2'd0,
    CRIT_GET_AWAY   = 2'd1,
    CRIT_PHONE_AWAY = 2'd2,
    CRIT_OTHER      = 2'd3
  } criterion_t;

endpackage

// File: design/pxv_if.sv
// Valid/ready channel interfaces for measurement requests and verdict results.
interface pxv_meas_if;
  logic                             valid;
  logic                             ready;
  logic                             measure_ok;
  logic [pxv_pkg::DIST_W-1:0]       range_cm;
  logic [pxv_pkg::CRIT_W-1:0]       criterion;

  modport source (output valid, measure_ok, range_cm, criterion, input ready);
  modport sink   (input valid, measure_ok, range_cm, criterion, output ready);
endinterface

interface pxv_result_if;
  logic valid;
  logic ready;
  logic criterion_met;
  logic is_near;
  logic verdict_valid;
  logic in_failsafe;

  modport source (output valid, criterion_met, is_near, verdict_valid, in_failsafe,
                  input ready);
  modport sink   (input valid, criterion_met, is_near, verdict_valid, in_failsafe,
                  output ready);
endinterface

// File: design/proximity_hysteresis_verdict.sv
// Proximity verdict with hysteresis thresholds, dwell debounce and abstain failsafe.
// An accepted request passes through the input register, then the result register;
// the run counters are updated as a request leaves the input register.
// Throughput: one request per cycle, limited only by the result channel's ready.
// Reset (synchronous, active high) clears the verdict, the run counters and both
// pipeline valids, and loads the thresholds with 150 cm and 300 cm.
module proximity_hysteresis_verdict #(
  parameter int unsigned NEAR_HOLD     = 3,
  parameter int unsigned AWAY_HOLD     = 6,
  parameter int unsigned ABSTAIN_LIMIT = 10,
  parameter int unsigned THRESH_MIN_CM = 30,
  parameter int unsigned THRESH_MAX_CM = 2000
) (
  input  logic                          clk,
  input  logic                          rst,
  pxv_meas_if.sink                      meas,
  pxv_result_if.source                  verdict,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pxv_pkg::ADDR_W-1:0]    paddr,
  input  logic [pxv_pkg::DATA_W-1:0]    pwdata,
  output logic [pxv_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam logic [pxv_pkg::CNT_W-1:0]  NearHold     = pxv_pkg::CNT_W'(NEAR_HOLD);
  localparam logic [pxv_pkg::CNT_W-1:0]  AwayHold     = pxv_pkg::CNT_W'(AWAY_HOLD);
  localparam logic [pxv_pkg::CNT_W-1:0]  AbstainLimit = pxv_pkg::CNT_W'(ABSTAIN_LIMIT);
  localparam logic [pxv_pkg::DIST_W-1:0] ThreshMin    = pxv_pkg::DIST_W'(THRESH_MIN_CM);
  localparam logic [pxv_pkg::DIST_W-1:0] ThreshMax    = pxv_pkg::DIST_W'(THRESH_MAX_CM);

  // Configuration registers.
  logic [pxv_pkg::DIST_W-1:0] near_threshold_cm;
  logic [pxv_pkg::DIST_W-1:0] away_threshold_cm;
  pxv_pkg::reg_index_t        reg_index;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign reg_index = pxv_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold_cm <= pxv_pkg::NEAR_DEFAULT_CM;
      away_threshold_cm <= pxv_pkg::AWAY_DEFAULT_CM;
    end else if (cfg_write) begin
      unique case (reg_index)
        pxv_pkg::REG_NEAR_THRESHOLD: near_threshold_cm <= pwdata[pxv_pkg::DIST_W-1:0];
        pxv_pkg::REG_AWAY_THRESHOLD: away_threshold_cm <= pwdata[pxv_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      pxv_pkg::REG_NEAR_THRESHOLD:
        prdata = {{(pxv_pkg::DATA_W-pxv_pkg::DIST_W){1'b0}}, near_threshold_cm};
      pxv_pkg::REG_AWAY_THRESHOLD:
        prdata = {{(pxv_pkg::DATA_W-pxv_pkg::DIST_W){1'b0}}, away_threshold_cm};
      default: prdata = '0;
    endcase
  end

  // Effective thresholds; the away side carries one extra bit for near plus the gap.
  logic [pxv_pkg::DIST_W-1:0] near_sel;
  logic [pxv_pkg::DIST_W-1:0] away_sel;
  logic [pxv_pkg::DIST_W-1:0] near_eff;
  logic [pxv_pkg::DIST_W:0]   away_eff;

  always_comb begin
    near_sel = (near_threshold_cm != '0) ? near_threshold_cm : pxv_pkg::NEAR_DEFAULT_CM;
    away_sel = (away_threshold_cm != '0) ? away_threshold_cm : pxv_pkg::AWAY_DEFAULT_CM;
    near_eff = (near_sel < ThreshMin) ? ThreshMin : near_sel;
    if (away_sel > ThreshMax) begin
      away_sel = ThreshMax;
    end
    if (away_sel <= near_eff) begin
      away_eff = {1'b0, near_eff} + pxv_pkg::BAND_GAP_CM;
    end else begin
      away_eff = {1'b0, away_sel};
    end
  end

  // Input register.
  logic                       s1_valid;
  logic                       s1_ok;
  logic [pxv_pkg::DIST_W-1:0] s1_dist;
  logic [pxv_pkg::CRIT_W-1:0] s1_crit;
  logic                       s1_adv;

  assign s1_adv     = s1_valid && (!verdict.valid || verdict.ready);
  assign meas.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (meas.ready) begin
      s1_valid <= meas.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (meas.valid && meas.ready) begin
      s1_ok   <= meas.measure_ok;
      s1_dist <= meas.range_cm;
      s1_crit <= meas.criterion;
    end
  end

  // Run counters and verdict.
  logic                      verdict_near;
  logic                      verdict_seen;
  logic [pxv_pkg::CNT_W-1:0] near_count;
  logic [pxv_pkg::CNT_W-1:0] away_count;
  logic [pxv_pkg::CNT_W-1:0] abstain_count;
  logic                      verdict_near_next;
  logic                      verdict_seen_next;
  logic [pxv_pkg::CNT_W-1:0] near_count_next;
  logic [pxv_pkg::CNT_W-1:0] away_count_next;
  logic [pxv_pkg::CNT_W-1:0] abstain_count_next;
  logic                      failsafe;
  logic                      met;

  always_comb begin
    verdict_near_next  = verdict_near;
    verdict_seen_next  = verdict_seen;
    near_count_next    = near_count;
    away_count_next    = away_count;
    abstain_count_next = abstain_count;
    if (!s1_ok) begin
      if (abstain_count != pxv_pkg::CNT_MAX) begin
        abstain_count_next = abstain_count + 1'b1;
      end
    end else begin
      abstain_count_next = '0;
      priority if (s1_dist < near_eff) begin
        away_count_next = '0;
        if (near_count != pxv_pkg::CNT_MAX) begin
          near_count_next = near_count + 1'b1;
        end
        if (near_count_next >= NearHold) begin
          verdict_near_next = 1'b1;
          verdict_seen_next = 1'b1;
        end
      end else if ({1'b0, s1_dist} > away_eff) begin
        near_count_next = '0;
        if (away_count != pxv_pkg::CNT_MAX) begin
          away_count_next = away_count + 1'b1;
        end
        if (away_count_next >= AwayHold) begin
          verdict_near_next = 1'b0;
          verdict_seen_next = 1'b1;
        end
      end else begin
        near_count_next = '0;
        away_count_next = '0;
      end
    end

    failsafe = abstain_count_next > AbstainLimit;
    if (failsafe || !verdict_seen_next) begin
      met = (pxv_pkg::criterion_t'(s1_crit) != pxv_pkg::CRIT_STAY_NEAR);
    end else begin
      unique case (pxv_pkg::criterion_t'(s1_crit))
        pxv_pkg::CRIT_STAY_NEAR:  met = verdict_near_next;
        pxv_pkg::CRIT_GET_AWAY:   met = !verdict_near_next;
        pxv_pkg::CRIT_PHONE_AWAY: met = !verdict_near_next;
        pxv_pkg::CRIT_OTHER:      met = 1'b1;
        default:                  met = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_near  <= 1'b0;
      verdict_seen  <= 1'b0;
      near_count    <= '0;
      away_count    <= '0;
      abstain_count <= '0;
    end else if (s1_adv) begin
      verdict_near  <= verdict_near_next;
      verdict_seen  <= verdict_seen_next;
      near_count    <= near_count_next;
      away_count    <= away_count_next;
      abstain_count <= abstain_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (s1_adv) begin
      verdict.valid <= 1'b1;
    end else if (verdict.ready) begin
      verdict.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      verdict.criterion_met <= met;
      verdict.is_near       <= verdict_near_next;
      verdict.verdict_valid <= verdict_seen_next;
      verdict.in_failsafe   <= failsafe;
    end
  end

`ifndef ASSERT_OFF
  a_near_needs_seen: assert property (@(posedge clk) disable iff (rst)
    verdict_near |-> verdict_seen)
    else $error("near verdict without any reached dwell");

  a_runs_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(near_count != '0 && away_count != '0))
    else $error("near and away runs both nonzero");

  a_ok_clears_abstain: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_ok) |=> (abstain_count == '0 && !verdict.in_failsafe))
    else $error("valid measurement left abstain run or failsafe set");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> verdict.valid)
    else $error("advanced request produced no result");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for the proximity hysteresis verdict block.
module tb;

  localparam int unsigned NEAR_HOLD     = 3;
  localparam int unsigned AWAY_HOLD     = 6;
  localparam int unsigned ABSTAIN_LIMIT = 10;
  localparam int unsigned THRESH_MIN_CM = 30;
  localparam int unsigned THRESH_MAX_CM = 2000;

  typedef struct packed {
    logic met;
    logic near;
    logic seen;
    logic failsafe;
  } outcome_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pxv_pkg::ADDR_W-1:0] paddr;
  logic [pxv_pkg::DATA_W-1:0] pwdata;
  logic [pxv_pkg::DATA_W-1:0] prdata;
  logic pready;

  pxv_meas_if   meas_ch ();
  pxv_result_if res_ch ();

  proximity_hysteresis_verdict #(
    .NEAR_HOLD     (NEAR_HOLD),
    .AWAY_HOLD     (AWAY_HOLD),
    .ABSTAIN_LIMIT (ABSTAIN_LIMIT),
    .THRESH_MIN_CM (THRESH_MIN_CM),
    .THRESH_MAX_CM (THRESH_MAX_CM)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .meas    (meas_ch),
    .verdict (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block: threshold registers, run counters and verdict.
  logic [pxv_pkg::DIST_W-1:0] near_reg = pxv_pkg::NEAR_DEFAULT_CM;
  logic [pxv_pkg::DIST_W-1:0] away_reg = pxv_pkg::AWAY_DEFAULT_CM;
  logic [pxv_pkg::CNT_W-1:0]  near_streak = '0;
  logic [pxv_pkg::CNT_W-1:0]  away_streak = '0;
  logic [pxv_pkg::CNT_W-1:0]  abstain_streak = '0;
  logic                       verdict_is_near = 1'b0;
  logic                       verdict_seen = 1'b0;

  outcome_t expected_verdicts[$];
  int errors = 0;
  int requests_sent = 0;
  int verdicts_checked = 0;
  int threshold_settings = 0;
  int sink_wait = 0;
  bit burst = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #4000000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic [pxv_pkg::DIST_W:0] eff_near();
    logic [pxv_pkg::DIST_W:0] n;
    n = (near_reg != 0) ? {1'b0, near_reg} : {1'b0, pxv_pkg::NEAR_DEFAULT_CM};
    if (n < THRESH_MIN_CM) n = (pxv_pkg::DIST_W+1)'(THRESH_MIN_CM);
    return n;
  endfunction

  function automatic logic [pxv_pkg::DIST_W:0] eff_away();
    logic [pxv_pkg::DIST_W:0] a;
    a = (away_reg != 0) ? {1'b0, away_reg} : {1'b0, pxv_pkg::AWAY_DEFAULT_CM};
    if (a > THRESH_MAX_CM) a = (pxv_pkg::DIST_W+1)'(THRESH_MAX_CM);
    if (a <= eff_near()) a = eff_near() + pxv_pkg::BAND_GAP_CM;
    return a;
  endfunction

  function automatic outcome_t predict_verdict(bit ok, logic [pxv_pkg::DIST_W-1:0] cm,
                                               pxv_pkg::criterion_t crit);
    outcome_t o;
    logic [pxv_pkg::DIST_W:0] n;
    logic [pxv_pkg::DIST_W:0] a;
    n = eff_near();
    a = eff_away();
    if (!ok) begin
      if (abstain_streak != pxv_pkg::CNT_MAX) abstain_streak++;
    end else begin
      abstain_streak = '0;
      if ({1'b0, cm} < n) begin
        away_streak = '0;
        if (near_streak != pxv_pkg::CNT_MAX) near_streak++;
        if (near_streak >= NEAR_HOLD) begin
          verdict_is_near = 1'b1;
          verdict_seen = 1'b1;
        end
      end else if ({1'b0, cm} > a) begin
        near_streak = '0;
        if (away_streak != pxv_pkg::CNT_MAX) away_streak++;
        if (away_streak >= AWAY_HOLD) begin
          verdict_is_near = 1'b0;
          verdict_seen = 1'b1;
        end
      end else begin
        near_streak = '0;
        away_streak = '0;
      end
    end
    o.failsafe = abstain_streak > ABSTAIN_LIMIT;
    o.near = verdict_is_near;
    o.seen = verdict_seen;
    if (o.failsafe || !verdict_seen) o.met = (crit != pxv_pkg::CRIT_STAY_NEAR);
    else begin
      case (crit)
        pxv_pkg::CRIT_STAY_NEAR: o.met = verdict_is_near;
        pxv_pkg::CRIT_OTHER:     o.met = 1'b1;
        default:                 o.met = !verdict_is_near;
      endcase
    end
    return o;
  endfunction

  function automatic logic [pxv_pkg::DIST_W-1:0] any_cm();
    return pxv_pkg::DIST_W'($urandom_range(0, 65535));
  endfunction

  // Valid stays high across back-to-back requests; it only drops for a gap.
  task automatic send_request(bit ok, logic [pxv_pkg::DIST_W-1:0] cm,
                              pxv_pkg::criterion_t crit);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      meas_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    meas_ch.valid = 1'b1;
    meas_ch.measure_ok = ok;
    meas_ch.range_cm = cm;
    meas_ch.criterion = crit;
    do @(posedge clk); while (!meas_ch.ready);
    expected_verdicts.push_back(predict_verdict(ok, cm, crit));
    requests_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    meas_ch.valid = 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  // Writes one threshold register and reads it back; the block must be idle.
  task automatic program_threshold(pxv_pkg::reg_index_t idx,
                                   logic [pxv_pkg::DIST_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {{(pxv_pkg::DATA_W-pxv_pkg::DIST_W){1'b0}}, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == pxv_pkg::REG_NEAR_THRESHOLD) near_reg = value;
    else away_reg = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[pxv_pkg::DIST_W-1:0] !== value) begin
      $error("prdata: expected %0d, got %0d", value, prdata[pxv_pkg::DIST_W-1:0]);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_thresholds(logic [pxv_pkg::DIST_W-1:0] near_cm,
                                logic [pxv_pkg::DIST_W-1:0] away_cm);
    wait_drain();
    program_threshold(pxv_pkg::REG_NEAR_THRESHOLD, near_cm);
    program_threshold(pxv_pkg::REG_AWAY_THRESHOLD, away_cm);
    threshold_settings++;
  endtask

  function automatic logic [pxv_pkg::DIST_W-1:0] near_dist();
    return pxv_pkg::DIST_W'($urandom_range(0, eff_near() - 1));
  endfunction

  function automatic logic [pxv_pkg::DIST_W-1:0] band_dist();
    logic [pxv_pkg::DIST_W:0] hi;
    hi = (eff_away() > 65535) ? 17'd65535 : eff_away();
    return pxv_pkg::DIST_W'($urandom_range(eff_near(), hi));
  endfunction

  function automatic logic [pxv_pkg::DIST_W-1:0] away_dist();
    if (eff_away() >= 65535) return band_dist();
    return pxv_pkg::DIST_W'($urandom_range(eff_away() + 1, 65535));
  endfunction

  function automatic pxv_pkg::criterion_t any_crit();
    return pxv_pkg::criterion_t'($urandom_range(0, 3));
  endfunction

  task automatic test_power_up();
    send_request(1'b0, '0, pxv_pkg::CRIT_STAY_NEAR);
    send_request(1'b0, '1, pxv_pkg::CRIT_GET_AWAY);
    send_request(1'b0, 16'h5555, pxv_pkg::CRIT_PHONE_AWAY);
    send_request(1'b0, 16'hAAAA, pxv_pkg::CRIT_OTHER);
  endtask

  task automatic test_near_hold();
    burst = 1;
    send_request(1'b1, 16'd0, pxv_pkg::CRIT_STAY_NEAR);
    send_request(1'b1, 16'd149, pxv_pkg::CRIT_STAY_NEAR);
    send_request(1'b1, 16'd149, pxv_pkg::CRIT_STAY_NEAR);
    burst = 0;
    // Both band edges are inclusive and clear the runs.
    send_request(1'b1, 16'd150, pxv_pkg::CRIT_GET_AWAY);
    send_request(1'b1, 16'd300, pxv_pkg::CRIT_PHONE_AWAY);
    send_request(1'b1, 16'd148, pxv_pkg::CRIT_OTHER);
  endtask

  task automatic test_away_hold();
    send_request(1'b1, 16'd301, pxv_pkg::CRIT_STAY_NEAR);
    send_request(1'b1, 16'd65535, pxv_pkg::CRIT_GET_AWAY);
    send_request(1'b1, 16'd1000, pxv_pkg::CRIT_PHONE_AWAY);
    send_request(1'b1, 16'd40000, pxv_pkg::CRIT_OTHER);
    send_request(1'b1, 16'd301, pxv_pkg::CRIT_STAY_NEAR);
    send_request(1'b1, 16'd65535, pxv_pkg::CRIT_GET_AWAY);
    send_request(1'b1, 16'd20000, pxv_pkg::CRIT_STAY_NEAR);
  endtask

  // A long abstention run crosses the failsafe limit and pins the counter at its top.
  task automatic test_abstain_failsafe();
    burst = 1;
    for (int i = 0; i < 262; i++) send_request(1'b0, any_cm(), any_crit());
    burst = 0;
    send_request(1'b1, 16'd500, pxv_pkg::CRIT_STAY_NEAR);
    send_request(1'b0, 16'd500, pxv_pkg::CRIT_PHONE_AWAY);
  endtask

  task automatic random_phase(int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 4);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          len = $urandom_range(1, 6);
          repeat (len) send_request(1'b1, near_dist(), any_crit());
        end
        3, 4, 5: begin
          len = $urandom_range(1, 9);
          repeat (len) send_request(1'b1, away_dist(), any_crit());
        end
        6: repeat (len) send_request(1'b1, band_dist(), any_crit());
        7: begin
          len = $urandom_range(1, 14);
          repeat (len) send_request(1'b0, any_cm(), any_crit());
        end
        8: repeat (len) send_request(1'($urandom_range(0, 1)), any_cm(), any_crit());
        default: begin
          send_request(1'b1, near_dist(), any_crit());
          send_request(1'b1, near_dist(), any_crit());
          send_request(1'b1, band_dist(), any_crit());
          len = 3;
        end
      endcase
      sent += len;
    end
  endtask

  task automatic test_threshold_settings();
    set_thresholds(16'd1, 16'd65535);
    random_phase(20);
    set_thresholds(16'd65535, 16'd0);
    random_phase(20);
    set_thresholds(16'd29, 16'd30);
    burst = 1;
    random_phase(20);
    burst = 0;
    set_thresholds(16'd31, 16'd2000);
    random_phase(20);
    set_thresholds(16'd1000, 16'd1000);
    random_phase(20);
    set_thresholds(16'd0, 16'd0);
    random_phase(20);
    set_thresholds(16'd200, 16'd2001);
    random_phase(20);
    set_thresholds(16'd150, 16'd300);
    random_phase(20);
  endtask

  always @(negedge clk) begin
    if (rst) res_ch.ready = 1'b0;
    else if (sink_wait > 0) begin
      res_ch.ready = 1'b0;
      sink_wait--;
    end else res_ch.ready = 1'b1;
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      sink_wait = burst ? 0 : $urandom_range(0, 11);
      verdicts_checked++;
      if (expected_verdicts.size() == 0) begin
        $error("verdict: result with no request outstanding");
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (res_ch.criterion_met !== want.met) begin
          $error("criterion_met: expected %0b, got %0b", want.met, res_ch.criterion_met);
          errors++;
        end
        if (res_ch.is_near !== want.near) begin
          $error("is_near: expected %0b, got %0b", want.near, res_ch.is_near);
          errors++;
        end
        if (res_ch.verdict_valid !== want.seen) begin
          $error("verdict_valid: expected %0b, got %0b", want.seen, res_ch.verdict_valid);
          errors++;
        end
        if (res_ch.in_failsafe !== want.failsafe) begin
          $error("in_failsafe: expected %0b, got %0b", want.failsafe, res_ch.in_failsafe);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    meas_ch.valid = 1'b0;
    meas_ch.measure_ok = 1'b0;
    meas_ch.range_cm = '0;
    meas_ch.criterion = pxv_pkg::CRIT_STAY_NEAR;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_power_up();
    test_near_hold();
    test_away_hold();
    test_abstain_failsafe();
    test_threshold_settings();

    wait_drain();
    repeat (6) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $error("verdict: %0d results never arrived", expected_verdicts.size());
      errors++;
    end
    $display("tb: %0d measurements sent, %0d verdicts compared", requests_sent,
             verdicts_checked);
    $display("tb: %0d threshold settings, including default, clamped and collapsed bands",
             threshold_settings);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
design/pxv_pkg.sv
design/pxv_if.sv
design/proximity_hysteresis_verdict.sv
tb/tb.sv
